>>> sv/lcdns_pkg.sv
// Shared types and constants for the character LCD nibble sequencer.
// No dependencies; every other file in this folder imports it.
package lcdns_pkg;

    localparam int ADDR_W      = 5;
    localparam int DATA_W      = 32;
    localparam int HOLD_W      = 18;
    localparam int STEP_W      = 5;
    localparam int INIT_STEPS  = 25;
    localparam int BYTE_STEPS  = 4;
    localparam int INIT_NIBBLE_STEPS = 9;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] LCD_LINE1     = 8'h80;
    localparam logic [7:0] LCD_LINE2     = 8'hC0;
    localparam logic [7:0] LCD_FUNC_SET  = 8'h28;
    localparam logic [7:0] LCD_DISP_ON   = 8'h0C;
    localparam logic [7:0] LCD_ENTRY     = 8'h06;
    localparam logic [7:0] LCD_CLS       = 8'h01;
    localparam logic [3:0] LCD_WAKE_NIB  = 4'h3;
    localparam logic [3:0] LCD_4BIT_NIB  = 4'h2;

    typedef enum logic [2:0] {
        CMD_INIT   = 3'd0,
        CMD_CHAR   = 3'd1,
        CMD_BYTE   = 3'd2,
        CMD_CURSOR = 3'd3,
        CMD_CLEAR  = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        REG_ENABLE_HIGH   = 3'd0,
        REG_ENABLE_LOW    = 3'd1,
        REG_COMMAND_SETTLE = 3'd2,
        REG_DATA_SETTLE   = 3'd3,
        REG_CLEAR_EXTRA   = 3'd4,
        REG_POWER_UP      = 3'd5,
        REG_INIT_NIBBLE   = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [7:0]  enable_high_us;
        logic [9:0]  enable_low_us;
        logic [15:0] command_settle_us;
        logic [9:0]  data_settle_us;
        logic [15:0] clear_extra_us;
        logic [16:0] power_up_us;
        logic [15:0] init_nibble_us;
    } cfg_t;

    typedef enum logic [1:0] {
        SETTLE_DATA  = 2'd0,
        SETTLE_CMD   = 2'd1,
        SETTLE_CLEAR = 2'd2
    } settle_t;

    typedef struct packed {
        logic       is_init;
        logic       rs;
        logic [7:0] value;
        settle_t    settle;
    } job_t;

    typedef enum logic [2:0] {
        HOLD_POWER     = 3'd0,
        HOLD_HIGH      = 3'd1,
        HOLD_LOW       = 3'd2,
        HOLD_LOW_INIT  = 3'd3,
        HOLD_LOW_DATA  = 3'd4,
        HOLD_LOW_CMD   = 3'd5,
        HOLD_LOW_CLEAR = 3'd6
    } hold_t;

    typedef struct packed {
        logic       push;
        logic       full;
    } qctl_t;

endpackage

>>> sv/lcdns_cfg.sv
// APB configuration register file for the LCD nibble sequencer.
// Depends on lcdns_pkg.
module lcdns_cfg
    import lcdns_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (idx)
                REG_ENABLE_HIGH:    cfg_next.enable_high_us    = pwdata[7:0];
                REG_ENABLE_LOW:     cfg_next.enable_low_us     = pwdata[9:0];
                REG_COMMAND_SETTLE: cfg_next.command_settle_us = pwdata[15:0];
                REG_DATA_SETTLE:    cfg_next.data_settle_us    = pwdata[9:0];
                REG_CLEAR_EXTRA:    cfg_next.clear_extra_us    = pwdata[15:0];
                REG_POWER_UP:       cfg_next.power_up_us       = pwdata[16:0];
                REG_INIT_NIBBLE:    cfg_next.init_nibble_us    = pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_ENABLE_HIGH:    prdata = {24'd0, cfg_reg.enable_high_us};
            REG_ENABLE_LOW:     prdata = {22'd0, cfg_reg.enable_low_us};
            REG_COMMAND_SETTLE: prdata = {16'd0, cfg_reg.command_settle_us};
            REG_DATA_SETTLE:    prdata = {22'd0, cfg_reg.data_settle_us};
            REG_CLEAR_EXTRA:    prdata = {16'd0, cfg_reg.clear_extra_us};
            REG_POWER_UP:       prdata = {15'd0, cfg_reg.power_up_us};
            REG_INIT_NIBBLE:    prdata = {16'd0, cfg_reg.init_nibble_us};
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enable_high_us    <= 8'd5;
            cfg_reg.enable_low_us     <= 10'd50;
            cfg_reg.command_settle_us <= 16'd2000;
            cfg_reg.data_settle_us    <= 10'd50;
            cfg_reg.clear_extra_us    <= 16'd2000;
            cfg_reg.power_up_us       <= 17'd50000;
            cfg_reg.init_nibble_us    <= 16'd5000;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> sv/lcdns_front.sv
// Request decoder: classifies each input transaction into a sequencer job.
// Depends on lcdns_pkg.
module lcdns_front
    import lcdns_pkg::*;
(
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_command,
    input  logic [7:0] s_byte_value,
    input  logic [1:0] s_row,
    input  logic [5:0] s_column,
    input  logic       q_full,
    output logic       q_push,
    output job_t       q_job
);

    logic       known;
    logic [7:0] cursor_addr;

    assign s_ready     = !q_full;
    assign cursor_addr = ((s_row == 2'd1) ? LCD_LINE1 : LCD_LINE2)
                         + {2'b00, s_column} - 8'd1;

    always_comb begin
        known         = 1'b1;
        q_job.is_init = 1'b0;
        q_job.rs      = 1'b0;
        q_job.value   = s_byte_value;
        q_job.settle  = SETTLE_CMD;
        case (cmd_t'(s_command))
            CMD_INIT:   q_job.is_init = 1'b1;
            CMD_CHAR: begin
                q_job.rs     = 1'b1;
                q_job.settle = SETTLE_DATA;
            end
            CMD_BYTE:   ;
            CMD_CURSOR: q_job.value = cursor_addr;
            CMD_CLEAR: begin
                q_job.value  = LCD_CLS;
                q_job.settle = SETTLE_CLEAR;
            end
            default:    known = 1'b0;
        endcase
    end

    // drop unknown commands
    assign q_push = s_valid && s_ready && known;

endmodule

>>> sv/lcdns_queue.sv
// Short job queue between the request decoder and the step sequencer.
// Depends on lcdns_pkg.
module lcdns_queue
    import lcdns_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  job_t  push_job,
    output logic  full,
    input  logic  pop,
    output logic  valid,
    output job_t  head_job
);

    job_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign valid    = (count_reg != '0);
    assign head_job = entry_reg[rd_ptr_reg];

    function automatic logic [QPTR_W-1:0] wrap_inc(input logic [QPTR_W-1:0] p);
        if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    always_comb begin
        wr_ptr_next = push ? wrap_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? wrap_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> sv/lcdns_back.sv
// Step sequencer: expands queued jobs into LCD pin steps behind an output register.
// Depends on lcdns_pkg.
module lcdns_back
    import lcdns_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  logic        q_valid,
    input  job_t        q_job,
    output logic        q_pop,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_reg_select,
    output logic        m_enable_pin,
    output logic [3:0]  m_data_nibble,
    output logic [HOLD_W-1:0] m_hold_us,
    output logic        m_last
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t             state_reg, state_next;
    job_t               job_reg, job_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               m_valid_reg, m_valid_next;
    logic               rs_reg;
    logic               en_reg;
    logic [3:0]         nib_reg;
    logic [HOLD_W-1:0]  hold_reg;
    logic               last_reg;

    logic               advance;
    logic               emit_rs;
    logic               emit_en;
    logic [3:0]         emit_nib;
    hold_t              emit_hold;
    logic [HOLD_W-1:0]  emit_hold_us;
    logic               emit_last;
    logic [7:0]         cur_byte;
    settle_t            cur_settle;
    logic [1:0]         pos;
    logic [STEP_W-1:0]  rel;

    assign advance = (state_reg == ST_RUN) && (!m_valid_reg || m_ready);

    always_comb begin
        emit_rs    = job_reg.rs;
        emit_en    = 1'b0;
        emit_nib   = '0;
        emit_hold  = HOLD_POWER;
        cur_byte   = job_reg.value;
        cur_settle = job_reg.settle;
        pos        = step_reg[1:0];
        rel        = '0;
        if (job_reg.is_init) begin
            emit_rs   = 1'b0;
            emit_last = (step_reg == STEP_W'(INIT_STEPS - 1));
        end else begin
            emit_last = (step_reg == STEP_W'(BYTE_STEPS - 1));
        end
        if (job_reg.is_init && step_reg == '0) begin
            emit_hold = HOLD_POWER;
        end else if (job_reg.is_init && step_reg < STEP_W'(INIT_NIBBLE_STEPS)) begin
            rel      = step_reg - 1'b1;
            emit_en  = !rel[0];
            emit_nib = (rel[2:1] == 2'd3) ? LCD_4BIT_NIB : LCD_WAKE_NIB;
            if (!rel[0]) begin
                emit_hold = HOLD_HIGH;
            end else if (rel[2:1] == 2'd3) begin
                emit_hold = HOLD_LOW;
            end else begin
                emit_hold = HOLD_LOW_INIT;
            end
        end else begin
            if (job_reg.is_init) begin
                rel = step_reg - STEP_W'(INIT_NIBBLE_STEPS);
                pos = rel[1:0];
                case (rel[3:2])
                    2'd0:    cur_byte = LCD_FUNC_SET;
                    2'd1:    cur_byte = LCD_DISP_ON;
                    2'd2:    cur_byte = LCD_ENTRY;
                    default: cur_byte = LCD_CLS;
                endcase
                cur_settle = (rel[3:2] == 2'd3) ? SETTLE_CLEAR : SETTLE_CMD;
            end
            emit_en  = !pos[0];
            emit_nib = pos[1] ? cur_byte[3:0] : cur_byte[7:4];
            if (!pos[0]) begin
                emit_hold = HOLD_HIGH;
            end else if (!pos[1]) begin
                emit_hold = HOLD_LOW;
            end else begin
                case (cur_settle)
                    SETTLE_DATA:  emit_hold = HOLD_LOW_DATA;
                    SETTLE_CLEAR: emit_hold = HOLD_LOW_CLEAR;
                    default:      emit_hold = HOLD_LOW_CMD;
                endcase
            end
        end
    end

    always_comb begin
        case (emit_hold)
            HOLD_POWER:    emit_hold_us = HOLD_W'(cfg.power_up_us);
            HOLD_HIGH:     emit_hold_us = HOLD_W'(cfg.enable_high_us);
            HOLD_LOW:      emit_hold_us = HOLD_W'(cfg.enable_low_us);
            HOLD_LOW_INIT: emit_hold_us = HOLD_W'(cfg.enable_low_us)
                                          + HOLD_W'(cfg.init_nibble_us);
            HOLD_LOW_DATA: emit_hold_us = HOLD_W'(cfg.enable_low_us)
                                          + HOLD_W'(cfg.data_settle_us);
            HOLD_LOW_CMD:  emit_hold_us = HOLD_W'(cfg.enable_low_us)
                                          + HOLD_W'(cfg.command_settle_us);
            HOLD_LOW_CLEAR: emit_hold_us = HOLD_W'(cfg.enable_low_us)
                                           + HOLD_W'(cfg.command_settle_us)
                                           + HOLD_W'(cfg.clear_extra_us);
            default:       emit_hold_us = '0;
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        job_next     = job_reg;
        step_next    = step_reg;
        q_pop        = 1'b0;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop      = 1'b1;
                    job_next   = q_job;
                    step_next  = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (advance) begin
                    m_valid_next = 1'b1;
                    step_next    = step_reg + 1'b1;
                    if (emit_last) begin
                        // chain straight into the next job
                        if (q_valid) begin
                            q_pop     = 1'b1;
                            job_next  = q_job;
                            step_next = '0;
                        end else begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        job_reg  <= job_next;
        step_reg <= step_next;
        if (advance) begin
            rs_reg   <= emit_rs;
            en_reg   <= emit_en;
            nib_reg  <= emit_nib;
            hold_reg <= emit_hold_us;
            last_reg <= emit_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_reg_select  = rs_reg;
    assign m_enable_pin  = en_reg;
    assign m_data_nibble = nib_reg;
    assign m_hold_us     = hold_reg;
    assign m_last        = last_reg;

    a_pop_needs_job: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("job popped from empty queue");

    a_init_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) && job_reg.is_init |-> step_reg < STEP_W'(INIT_STEPS))
        else $error("init step counter overran");

    a_byte_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) && !job_reg.is_init |-> step_reg < STEP_W'(BYTE_STEPS))
        else $error("byte step counter overran");

    a_last_is_low: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && emit_last |-> !emit_en)
        else $error("run ended on an enable-high step");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |=> m_valid_reg && $stable(hold_reg))
        else $error("pending step changed under stall");

endmodule

>>> sv/char_lcd_nibble_sequencer.sv
// Character LCD (HD44780-style, 4-bit bus) nibble sequencer, top level.
// Depends on lcdns_pkg, lcdns_cfg, lcdns_front, lcdns_queue, lcdns_back.
//
// Usage:
//   s_* channel takes one request per transaction: 0 init, 1 write character,
//   2 write command byte, 3 set cursor (row, column), 4 clear. Other command
//   codes are consumed and produce nothing.
//   m_* channel returns one pin step per transaction: RS, E, D7..D4 and the
//   hold time in microseconds; m_last marks the final step of a request.
//   Character, command, cursor and clear requests give 4 steps, init gives 25.
//   The first step passes through the job queue, the job register and the output register.
//   Throughput: one step per cycle from the sequencer while m_ready does not stall
//   it; a job already queued when a request ends chains on with no gap.
//   A 2-entry job queue lets requests be taken while steps are still going out.
//   When m_ready is low the current step holds and the sequencer waits; the
//   queue fills and then s_ready drops.
//   Reset (aresetn low, synchronous) empties the queue, drops any pending
//   step and loads the timing registers with their defaults.
//   Timing registers sit on the APB port at byte address 4*index; pready is
//   always high. Write them only while no request is in flight.
module char_lcd_nibble_sequencer
    import lcdns_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [2:0]        s_command,
    input  logic [7:0]        s_byte_value,
    input  logic [1:0]        s_row,
    input  logic [5:0]        s_column,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_reg_select,
    output logic              m_enable_pin,
    output logic [3:0]        m_data_nibble,
    output logic [HOLD_W-1:0] m_hold_us,
    output logic              m_last
);

    cfg_t  cfg;
    qctl_t qctl;
    job_t  push_job;
    job_t  head_job;
    logic  q_valid;
    logic  q_pop;

    lcdns_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lcdns_front u_front (
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_command    (s_command),
        .s_byte_value (s_byte_value),
        .s_row        (s_row),
        .s_column     (s_column),
        .q_full       (qctl.full),
        .q_push       (qctl.push),
        .q_job        (push_job)
    );

    lcdns_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (qctl.push),
        .push_job (push_job),
        .full     (qctl.full),
        .pop      (q_pop),
        .valid    (q_valid),
        .head_job (head_job)
    );

    lcdns_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .q_valid       (q_valid),
        .q_job         (head_job),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_reg_select  (m_reg_select),
        .m_enable_pin  (m_enable_pin),
        .m_data_nibble (m_data_nibble),
        .m_hold_us     (m_hold_us),
        .m_last        (m_last)
    );

endmodule
